### rtl/core/cobs_frame_receiver_crc16_top_defines.svh
// Assertion macros shared by the frame receiver modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef COBS_FRAME_RECEIVER_CRC16_TOP_DEFINES_SVH
`define COBS_FRAME_RECEIVER_CRC16_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define CFR_ASSERT(name, clock, resetn, prop) \
    name: assert property (@(posedge clock) disable iff (!resetn) (prop)) \
        else $error("frame receiver check failed");

// Check that a condition holds in the cycle after a trigger.
`define CFR_ASSERT_NEXT(name, clock, resetn, trig, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (trig) |=> (cons)) \
        else $error("frame receiver check failed");

`else

`define CFR_ASSERT(name, clock, resetn, prop)
`define CFR_ASSERT_NEXT(name, clock, resetn, trig, cons)

`endif

`endif

### rtl/core/cfr_pkg.sv
package cfr_pkg;

    // Default frame store depth
    localparam int FRAME_BYTES_DEF = 64;

    // Frame layout
    localparam int HDR_BYTES   = 3;
    localparam int MIN_DECODED = 5;
    localparam int MAX_RESULTS = 63;

    // Result status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED   = 2'd1;
    localparam logic [1:0] STATUS_BAD_VERSION = 2'd2;
    localparam logic [1:0] STATUS_BAD_CRC     = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_CRC_POLYNOMIAL   = 2'd0;
    localparam logic [1:0] CFG_CRC_INITIAL      = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_VERSION = 2'd2;
    localparam logic [1:0] CFG_GAP_TIMEOUT_MS   = 2'd3;

    // Configuration reset values
    localparam logic [15:0] CRC_POLYNOMIAL_RST   = 16'h1021;
    localparam logic [15:0] CRC_INITIAL_RST      = 16'hFFFF;
    localparam logic [7:0]  EXPECTED_VERSION_RST = 8'd1;
    localparam logic [31:0] GAP_TIMEOUT_MS_RST   = 32'd100;

    localparam logic [15:0] CRC_MSB       = 16'h8000;
    localparam logic [7:0]  COBS_MAX_CODE = 8'hFF;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       step;
        logic       frame_clear;
        logic       crc_start;
        logic       crc_step;
        logic       emit_start;
        logic       emit_rd;
        logic       out_load_ok;
        logic       out_load_err;
        logic [1:0] err_code;
    } cfr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic byte_zero;
        logic frame_empty;
        logic malformed;
        logic version_bad;
        logic crc_done;
        logic crc_ok;
        logic last_result;
        logic out_free;
    } cfr_stat_t;

    // Advance an MSB-first CRC-16 by one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/cfr_if.sv
// Input byte channel
interface cfr_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [31:0] now_ms;

    modport source (output valid, output data_byte, output now_ms, input ready);
    modport sink (input valid, input data_byte, input now_ms, output ready);
endinterface

// Result channel
interface cfr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] msg_id;
    logic [7:0] seq;
    logic [5:0] payload_count;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic       last;

    modport source (output valid, output status, output msg_id, output seq,
                    output payload_count, output payload_byte, output payload_index,
                    output last, input ready);
    modport sink (input valid, input status, input msg_id, input seq,
                  input payload_count, input payload_byte, input payload_index,
                  input last, output ready);
endinterface

### rtl/core/cfr_controller.sv
`include "cobs_frame_receiver_crc16_top_defines.svh"

module cfr_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cfr_pkg::cfr_stat_t st,
    output cfr_pkg::cfr_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROC,
        S_CRC,
        S_ERR,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] err_code_reg;
    logic [1:0] err_code_next;

    // Hold state and error code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            err_code_reg <= cfr_pkg::STATUS_MALFORMED;
        end
        else
        begin
            state_reg    <= state_next;
            err_code_reg <= err_code_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Sequence one request through decode, check and emit
    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        err_code_next = err_code_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (!st.byte_zero)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.frame_clear = 1'b1;
                    if (st.frame_empty)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (st.malformed)
                    begin
                        err_code_next = cfr_pkg::STATUS_MALFORMED;
                        state_next    = S_ERR;
                    end
                    else if (st.version_bad)
                    begin
                        err_code_next = cfr_pkg::STATUS_BAD_VERSION;
                        state_next    = S_ERR;
                    end
                    else
                    begin
                        cmd.crc_start = 1'b1;
                        state_next    = S_CRC;
                    end
                end
            end
            S_CRC:
            begin
                cmd.crc_step = 1'b1;
                if (st.crc_done)
                begin
                    if (st.crc_ok)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = S_EMIT_RD;
                    end
                    else
                    begin
                        err_code_next = cfr_pkg::STATUS_BAD_CRC;
                        state_next    = S_ERR;
                    end
                end
            end
            S_ERR:
            begin
                if (st.out_free)
                begin
                    cmd.out_load_err = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (st.out_free)
                begin
                    cmd.out_load_ok = 1'b1;
                    state_next      = st.last_result ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.err_code = err_code_reg;
    end

    `CFR_ASSERT(a_load_when_free, clk, rst_n, (cmd.out_load_ok || cmd.out_load_err) |-> st.out_free)
    `CFR_ASSERT_NEXT(a_accept_to_proc, clk, rst_n, cmd.load, state_reg == S_PROC)
    `CFR_ASSERT(a_crc_on_delim, clk, rst_n, cmd.crc_start |-> (st.byte_zero && !st.frame_empty))

endmodule

### rtl/core/cfr_datapath.sv
`include "cobs_frame_receiver_crc16_top_defines.svh"

module cfr_datapath #(
    parameter int FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic [7:0]        data_byte,
    input  logic [31:0]       now_ms,
    input  logic              res_ready,
    input  cfr_pkg::cfr_cmd_t  cmd,
    output cfr_pkg::cfr_stat_t st,
    output logic              res_valid,
    output logic [1:0]        res_status,
    output logic [7:0]        res_msg_id,
    output logic [7:0]        res_seq,
    output logic [5:0]        res_payload_count,
    output logic [7:0]        res_payload_byte,
    output logic [5:0]        res_payload_index,
    output logic              res_last
);

    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int AW = $clog2(FRAME_BYTES);
    localparam int EW = (CW > 7) ? CW : 7;

    // Configuration registers
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_init_reg;
    logic [7:0]  version_reg;
    logic [31:0] gap_timeout_reg;

    // Input capture
    logic [7:0]  byte_reg;
    logic        hit_reg;
    logic [31:0] last_time_reg;
    logic [31:0] gap;

    // Streaming decoder state
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [7:0]    rem_reg, rem_next;
    logic          ovf_reg, ovf_next;
    logic          prev_ff_reg, prev_ff_next;
    logic [CW-1:0] eff_fill, eff_wr;
    logic [7:0]    eff_rem;
    logic          eff_ovf;

    // Decoded store write side
    logic          mem_we;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    dec_mem [FRAME_BYTES];

    // Header and trailer window
    logic [7:0] hdr0_reg, hdr1_reg, hdr2_reg;
    logic [7:0] win1_reg, win2_reg;

    // Check and emit state
    logic [CW-1:0] body_reg;
    logic [CW-1:0] ptr_reg;
    logic          rd_vld_reg;
    logic [7:0]    rd_data_reg;
    logic          rd_en;
    logic          crc_rd;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] emit_addr;
    logic [15:0]   crc_reg;
    logic [5:0]    k_reg;
    logic [EW-1:0] plen_e;
    logic          plen_zero;
    logic [5:0]    plen_sat;
    logic [5:0]    nres;
    logic          out_valid_reg;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_poly_reg    <= cfr_pkg::CRC_POLYNOMIAL_RST;
            crc_init_reg    <= cfr_pkg::CRC_INITIAL_RST;
            version_reg     <= cfr_pkg::EXPECTED_VERSION_RST;
            gap_timeout_reg <= cfr_pkg::GAP_TIMEOUT_MS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cfr_pkg::CFG_CRC_POLYNOMIAL:   crc_poly_reg    <= cfg_data[15:0];
                cfr_pkg::CFG_CRC_INITIAL:      crc_init_reg    <= cfg_data[15:0];
                cfr_pkg::CFG_EXPECTED_VERSION: version_reg     <= cfg_data[7:0];
                cfr_pkg::CFG_GAP_TIMEOUT_MS:   gap_timeout_reg <= cfg_data;
                default:                       crc_poly_reg    <= crc_poly_reg;
            endcase
        end
    end

    // Capture request and evaluate inter-byte gap
    assign gap = now_ms - last_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            hit_reg       <= 1'b0;
        end
        else if (cmd.load)
        begin
            last_time_reg <= now_ms;
            hit_reg       <= (gap > gap_timeout_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= data_byte;
        end
    end

    // Drop the partial frame on timeout
    assign eff_fill = hit_reg ? '0 : fill_reg;
    assign eff_wr   = hit_reg ? '0 : wr_reg;
    assign eff_rem  = hit_reg ? 8'd0 : rem_reg;
    assign eff_ovf  = hit_reg ? 1'b0 : ovf_reg;

    assign mem_waddr = eff_wr[AW-1:0];

    // Decode one stored byte: code bytes open a group, data bytes copy through
    always_comb
    begin
        fill_next    = fill_reg;
        wr_next      = wr_reg;
        rem_next     = rem_reg;
        ovf_next     = ovf_reg;
        prev_ff_next = prev_ff_reg;
        mem_we       = 1'b0;
        mem_wdata    = byte_reg;
        if (cmd.frame_clear)
        begin
            fill_next    = '0;
            wr_next      = '0;
            rem_next     = 8'd0;
            ovf_next     = 1'b0;
            prev_ff_next = 1'b0;
        end
        else if (cmd.step)
        begin
            fill_next = eff_fill;
            wr_next   = eff_wr;
            rem_next  = eff_rem;
            ovf_next  = eff_ovf;
            if (eff_fill != CW'(FRAME_BYTES))
            begin
                fill_next = eff_fill + CW'(1);
                if (eff_rem == 8'd0)
                begin
                    rem_next     = byte_reg - 8'd1;
                    prev_ff_next = (byte_reg == cfr_pkg::COBS_MAX_CODE);
                    if ((eff_fill != '0) && !prev_ff_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = 8'd0;
                    end
                end
                else
                begin
                    rem_next = eff_rem - 8'd1;
                    mem_we   = 1'b1;
                end
                if (mem_we)
                begin
                    wr_next = eff_wr + CW'(1);
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            wr_reg      <= '0;
            rem_reg     <= 8'd0;
            ovf_reg     <= 1'b0;
            prev_ff_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            wr_reg      <= wr_next;
            rem_reg     <= rem_next;
            ovf_reg     <= ovf_next;
            prev_ff_reg <= prev_ff_next;
        end
    end

    // Keep the header bytes and the last two decoded bytes
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            if (eff_wr == CW'(0))
            begin
                hdr0_reg <= mem_wdata;
            end
            if (eff_wr == CW'(1))
            begin
                hdr1_reg <= mem_wdata;
            end
            if (eff_wr == CW'(2))
            begin
                hdr2_reg <= mem_wdata;
            end
            win2_reg <= win1_reg;
            win1_reg <= mem_wdata;
        end
    end

    // Decoded store: one write, one registered read
    assign crc_rd    = cmd.crc_step && (ptr_reg < body_reg);
    assign rd_en     = crc_rd || cmd.emit_rd;
    assign emit_addr = EW'(k_reg) + EW'(cfr_pkg::HDR_BYTES);
    assign rd_addr   = cmd.crc_step ? ptr_reg[AW-1:0] : emit_addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dec_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= dec_mem[rd_addr];
        end
    end

    // Sweep the frame body through the CRC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_reg   <= '0;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
            k_reg      <= 6'd0;
        end
        else
        begin
            if (cmd.frame_clear)
            begin
                body_reg <= wr_reg - CW'(2);
            end
            if (cmd.crc_start)
            begin
                ptr_reg    <= '0;
                rd_vld_reg <= 1'b0;
            end
            else
            begin
                rd_vld_reg <= crc_rd;
                if (crc_rd)
                begin
                    ptr_reg <= ptr_reg + CW'(1);
                end
            end
            if (cmd.emit_start)
            begin
                k_reg <= 6'd0;
            end
            else if (cmd.out_load_ok)
            begin
                k_reg <= k_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.crc_start)
        begin
            crc_reg <= crc_init_reg;
        end
        else if (cmd.crc_step && rd_vld_reg)
        begin
            crc_reg <= cfr_pkg::crc16_byte(crc_reg, rd_data_reg, crc_poly_reg);
        end
    end

    // Payload length and result count
    assign plen_e    = EW'(body_reg) - EW'(cfr_pkg::HDR_BYTES);
    assign plen_zero = (plen_e == '0);
    assign plen_sat  = (plen_e > EW'(cfr_pkg::MAX_RESULTS)) ? 6'(cfr_pkg::MAX_RESULTS)
                                                            : plen_e[5:0];
    assign nres      = plen_zero ? 6'd1 : plen_sat;

    // Status to controller
    always_comb
    begin
        st             = '0;
        st.byte_zero   = (byte_reg == 8'd0);
        st.frame_empty = (eff_fill == '0);
        st.malformed   = eff_ovf || (eff_rem != 8'd0) || (eff_wr < CW'(cfr_pkg::MIN_DECODED));
        st.version_bad = (hdr0_reg != version_reg);
        st.crc_done    = (ptr_reg == body_reg) && !rd_vld_reg;
        st.crc_ok      = (crc_reg == {win1_reg, win2_reg});
        st.last_result = ((k_reg + 6'd1) == nres);
        st.out_free    = !out_valid_reg || res_ready;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load_ok || cmd.out_load_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load_ok)
        begin
            res_status        <= cfr_pkg::STATUS_OK;
            res_msg_id        <= hdr1_reg;
            res_seq           <= hdr2_reg;
            res_payload_count <= plen_sat;
            res_payload_byte  <= plen_zero ? 8'd0 : rd_data_reg;
            res_payload_index <= k_reg;
            res_last          <= st.last_result;
        end
        else if (cmd.out_load_err)
        begin
            res_status        <= cmd.err_code;
            res_msg_id        <= 8'd0;
            res_seq           <= 8'd0;
            res_payload_count <= 6'd0;
            res_payload_byte  <= 8'd0;
            res_payload_index <= 6'd0;
            res_last          <= 1'b1;
        end
    end

    assign res_valid = out_valid_reg;

    `CFR_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= CW'(FRAME_BYTES))
    `CFR_ASSERT(a_decode_lag, clk, rst_n, (fill_reg != '0) |-> (wr_reg < fill_reg))
    `CFR_ASSERT(a_sweep_bound, clk, rst_n, cmd.crc_step |-> (ptr_reg <= body_reg))

endmodule

### rtl/core/cobs_frame_receiver_crc16_top.sv
// Non-delimiter byte: accept, then decode step; no result.
// Delimiter: accept, then check; for a good frame a CRC sweep of the body
// (one decoded byte per cycle) and per result a store read, then a load once the output is free.
// An error status loads after the check or the sweep once the output is free; the
// next byte is taken while the last result still sits in the output register.
// Reset (rst_n low, asynchronous) clears control state and loads register defaults.
module cobs_frame_receiver_crc16_top #(
    parameter int FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cfr_byte_if.sink      byte_ch,
    cfr_result_if.source  result_ch,
    input  logic          cfg_write,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    cfr_pkg::cfr_cmd_t  cmd;
    cfr_pkg::cfr_stat_t st;
    logic               in_ready;

    assign byte_ch.ready = in_ready;

    // Sequence requests
    cfr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_ch.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Decode, check and emit
    cfr_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .data_byte         (byte_ch.data_byte),
        .now_ms            (byte_ch.now_ms),
        .res_ready         (result_ch.ready),
        .cmd               (cmd),
        .st                (st),
        .res_valid         (result_ch.valid),
        .res_status        (result_ch.status),
        .res_msg_id        (result_ch.msg_id),
        .res_seq           (result_ch.seq),
        .res_payload_count (result_ch.payload_count),
        .res_payload_byte  (result_ch.payload_byte),
        .res_payload_index (result_ch.payload_index),
        .res_last          (result_ch.last)
    );

endmodule
